// ===== sv/fct_pkg.sv =====
// shared types, constants and controller/datapath command structs for the
// fat12 cluster table engine; no dependencies
package fct_pkg;

    localparam int ENTRIES     = 4096;
    localparam int WORDS       = (ENTRIES + 1) / 2;
    localparam int STORE_DEPTH = 2048;
    localparam int WORD_W      = 24;
    localparam int ENTRY_W     = 12;
    localparam int ADDR_W      = 11;
    localparam int CNT_W       = 13;
    localparam int SECTOR_BIAS = 31;

    localparam logic [CNT_W-1:0]   ENTRIES_C = CNT_W'(ENTRIES);
    localparam logic [ENTRY_W-1:0] WORDS_C   = ENTRY_W'(WORDS);
    localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(WORDS - 1);
    localparam logic [ENTRY_W-1:0] END_MARK  = 12'hFFF;

    localparam logic [15:0]      ROOT_RST  = 16'd19;
    localparam logic [CNT_W-1:0] LIMIT_RST = 13'd512;

    localparam logic REG_ROOT  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        F_LOAD  = 3'd0,
        F_READ  = 3'd1,
        F_WRITE = 3'd2,
        F_FREE  = 3'd3,
        F_CHAIN = 3'd4,
        F_COUNT = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_CHAIN_ERR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_RD,
        S_RMW,
        S_SCAN,
        S_CH_CHK,
        S_CH_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] position;
        logic [11:0] entry_value;
        logic [10:0] pair_index;
        logic [23:0] pair_data;
        logic [15:0] dir_sector;
    } t_item;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic load_wr;
        logic rd_issue;
        logic rmw;
        logic scan_step;
        logic ch_check;
        logic ch_follow;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic free_empty;
        logic ch_quick;
        logic scan_end;
        logic ch_stop;
        logic ch_end;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/fct_item_if.sv =====
// input item channel: valid/ready handshake and request fields
// depends on nothing
interface fct_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [11:0] position;
    logic [11:0] entry_value;
    logic [10:0] pair_index;
    logic [23:0] pair_data;
    logic [15:0] dir_sector;

    modport source (output valid, func, position, entry_value, pair_index, pair_data,
                    dir_sector, input ready);
    modport sink (input valid, func, position, entry_value, pair_index, pair_data,
                  dir_sector, output ready);
endinterface

// ===== sv/fct_result_if.sv =====
// result channel: valid/ready handshake with value and status
// depends on nothing
interface fct_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

// ===== sv/fct_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module fct_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/fct_cfg.sv =====
// apb-style configuration registers: root directory sector and free search limit
// depends on fct_pkg
module fct_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output logic [15:0] o_root,
    output logic [fct_pkg::CNT_W-1:0] o_limit
);
    logic [15:0]               r_root;
    logic [fct_pkg::CNT_W-1:0] r_limit;
    logic                      wr;

    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= fct_pkg::ROOT_RST;
            r_limit <= fct_pkg::LIMIT_RST;
        end else if (wr) begin
            if (i_paddr[2] == fct_pkg::REG_ROOT) begin
                r_root <= i_pwdata[15:0];
            end else begin
                r_limit <= i_pwdata[fct_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (i_paddr[2] == fct_pkg::REG_ROOT) begin
            o_prdata = {16'd0, r_root};
        end else begin
            o_prdata = {{(32 - fct_pkg::CNT_W){1'b0}}, r_limit};
        end
    end

    assign o_pready = 1'b1;
    assign o_root   = r_root;
    assign o_limit  = r_limit;
endmodule

// ===== sv/fct_ctrl.sv =====
// controller: sequences the clearing sweep, table operations and result hand-off
// depends on fct_pkg
module fct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_in_func,
    input  fct_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output fct_pkg::t_dp_cmd o_cmd
);
    fct_pkg::t_state r_state;
    fct_pkg::t_state n_state;
    logic            acc;

    assign acc = i_in_valid && (r_state == fct_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fct_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fct_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = fct_pkg::S_IDLE;
                end
            end
            fct_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = acc;
                if (acc) begin
                    case (fct_pkg::t_func'(i_in_func))
                        fct_pkg::F_LOAD:  n_state = fct_pkg::S_LOAD;
                        fct_pkg::F_READ:  n_state = fct_pkg::S_RD;
                        fct_pkg::F_WRITE: n_state = fct_pkg::S_RD;
                        fct_pkg::F_FREE:  n_state = i_sts.free_empty ? fct_pkg::S_DONE
                                                                     : fct_pkg::S_SCAN;
                        fct_pkg::F_CHAIN: n_state = i_sts.ch_quick ? fct_pkg::S_DONE
                                                                   : fct_pkg::S_CH_CHK;
                        fct_pkg::F_COUNT: n_state = fct_pkg::S_SCAN;
                        default:          n_state = fct_pkg::S_DONE;
                    endcase
                end
            end
            fct_pkg::S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = fct_pkg::S_DONE;
            end
            fct_pkg::S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = fct_pkg::S_RMW;
            end
            fct_pkg::S_RMW: begin
                o_cmd.rmw = 1'b1;
                n_state   = fct_pkg::S_DONE;
            end
            fct_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = fct_pkg::S_DONE;
                end
            end
            fct_pkg::S_CH_CHK: begin
                o_cmd.ch_check = 1'b1;
                n_state = i_sts.ch_stop ? fct_pkg::S_DONE : fct_pkg::S_CH_WAIT;
            end
            fct_pkg::S_CH_WAIT: begin
                o_cmd.ch_follow = 1'b1;
                n_state = i_sts.ch_end ? fct_pkg::S_DONE : fct_pkg::S_CH_CHK;
            end
            fct_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fct_pkg::S_CLEAR;
            end
        endcase
    end
endmodule

// ===== sv/fct_dp.sv =====
// datapath: table ram, entry pack/unpack, scan and chain registers, result register
// depends on fct_pkg and fct_ram
module fct_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fct_pkg::t_dp_cmd i_cmd,
    input  fct_pkg::t_item   i_item,
    input  logic [15:0]      i_root,
    input  logic [fct_pkg::CNT_W-1:0] i_limit,
    input  logic             i_out_ready,
    output fct_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    output logic [15:0]      o_out_value,
    output logic [1:0]       o_out_status
);
    localparam int AW = fct_pkg::ADDR_W;
    localparam int EW = fct_pkg::ENTRY_W;
    localparam int CW = fct_pkg::CNT_W;

    // latched item
    fct_pkg::t_func  r_func;
    logic [EW-1:0]   r_pos;
    logic [EW-1:0]   r_eval;
    logic [AW-1:0]   r_pidx;
    logic [23:0]     r_pdata;

    // control counters
    logic [AW-1:0]   r_cnt;
    logic            r_chk_vld;
    logic [AW-1:0]   r_chk_word;
    logic            r_o_valid;

    logic [15:0]     r_cl;
    logic [CW-1:0]   r_steps;
    logic [15:0]     r_value;
    fct_pkg::t_status r_status;
    logic [15:0]     r_o_value;
    logic [1:0]      r_o_status;

    logic                      we;
    logic [AW-1:0]             waddr;
    logic [fct_pkg::WORD_W-1:0] wdata;
    logic [AW-1:0]             raddr;
    logic [fct_pkg::WORD_W-1:0] rdata;

    logic [EW-1:0] lo;
    logic [EW-1:0] hi;
    logic [EW-1:0] half;
    logic [CW-1:0] lim_eff;
    logic [CW-1:0] bound;
    logic [EW-1:0] e0;
    logic [EW-1:0] e1;
    logic          in0;
    logic          in1;
    logic          last;
    logic          f0;
    logic          f1;
    logic          is_free;
    logic          pos_ok;
    logic          pidx_ok;

    fct_ram #(
        .WIDTH (fct_pkg::WORD_W),
        .DEPTH (fct_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign lo      = rdata[EW-1:0];
    assign hi      = rdata[2*EW-1:EW];
    assign half    = r_cl[0] ? hi : lo;
    assign lim_eff = (i_limit > fct_pkg::ENTRIES_C) ? fct_pkg::ENTRIES_C : i_limit;
    assign is_free = (r_func == fct_pkg::F_FREE);
    assign pos_ok  = ({1'b0, r_pos} < fct_pkg::ENTRIES_C);
    assign pidx_ok = ({1'b0, r_pidx} < fct_pkg::WORDS_C);

    // scan checks both entries of the word whose read was issued in the previous cycle
    assign bound = is_free ? lim_eff : fct_pkg::ENTRIES_C;
    assign e0    = {r_chk_word, 1'b0};
    assign e1    = {r_chk_word, 1'b1};
    assign in0   = ({1'b0, e0} < bound);
    assign in1   = ({1'b0, e1} < bound);
    assign last  = (({1'b0, e1} + CW'(1)) >= bound);
    assign f0    = in0 && (lo == '0);
    assign f1    = in1 && (hi == '0);

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = '0;
        raddr = r_cnt;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.load_wr) begin
            we    = pidx_ok;
            waddr = r_pidx;
            wdata = r_pdata;
        end else if (i_cmd.rmw) begin
            we    = (r_func == fct_pkg::F_WRITE) && pos_ok;
            waddr = r_pos[EW-1:1];
            wdata = r_pos[0] ? {r_eval, lo} : {hi, r_eval};
        end
        if (i_cmd.rd_issue) begin
            raddr = r_pos[EW-1:1];
        end else if (i_cmd.ch_check) begin
            raddr = r_cl[EW-1:1];
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_cnt == fct_pkg::CLR_LAST);
        o_sts.free_empty = (lim_eff == '0);
        o_sts.ch_quick   = (i_item.dir_sector == i_root)
                        || (i_item.dir_sector < 16'(fct_pkg::SECTOR_BIAS));
        o_sts.scan_end   = r_chk_vld && ((is_free && (f0 || f1)) || last);
        o_sts.ch_stop    = (r_cl >= 16'(fct_pkg::ENTRIES)) || (r_steps == fct_pkg::ENTRIES_C);
        o_sts.ch_end     = (half == fct_pkg::END_MARK);
        o_sts.out_free   = !r_o_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step || i_cmd.scan_step) begin
                r_cnt <= r_cnt + AW'(1);
            end else if (i_cmd.accept) begin
                r_cnt <= '0;
            end
            if (i_cmd.accept) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_vld <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= fct_pkg::t_func'(i_item.func);
            r_pos    <= i_item.position;
            r_eval   <= i_item.entry_value;
            r_pidx   <= i_item.pair_index;
            r_pdata  <= i_item.pair_data;
            r_cl     <= i_item.dir_sector - 16'(fct_pkg::SECTOR_BIAS);
            r_steps  <= '0;
            if (fct_pkg::t_func'(i_item.func) == fct_pkg::F_CHAIN
                    && i_item.dir_sector == i_root) begin
                r_value <= i_item.dir_sector;
            end else begin
                r_value <= '0;
            end
            if (fct_pkg::t_func'(i_item.func) == fct_pkg::F_FREE && o_sts.free_empty) begin
                r_status <= fct_pkg::ST_NO_FREE;
            end else if (fct_pkg::t_func'(i_item.func) == fct_pkg::F_CHAIN
                    && i_item.dir_sector != i_root
                    && i_item.dir_sector < 16'(fct_pkg::SECTOR_BIAS)) begin
                r_status <= fct_pkg::ST_CHAIN_ERR;
            end else begin
                r_status <= fct_pkg::ST_OK;
            end
        end
        if (i_cmd.rmw && r_func == fct_pkg::F_READ && pos_ok) begin
            r_value <= {4'd0, r_pos[0] ? hi : lo};
        end
        if (i_cmd.scan_step) begin
            r_chk_word <= r_cnt;
            if (r_chk_vld) begin
                if (is_free) begin
                    if (f0) begin
                        r_value <= {4'd0, e0};
                    end else if (f1) begin
                        r_value <= {4'd0, e1};
                    end else if (last) begin
                        r_status <= fct_pkg::ST_NO_FREE;
                    end
                end else begin
                    r_value <= r_value + 16'(f0) + 16'(f1);
                end
            end
        end
        if (i_cmd.ch_check) begin
            if (o_sts.ch_stop) begin
                r_status <= fct_pkg::ST_CHAIN_ERR;
            end else begin
                r_steps <= r_steps + CW'(1);
            end
        end
        if (i_cmd.ch_follow) begin
            if (o_sts.ch_end) begin
                r_value <= r_cl + 16'(fct_pkg::SECTOR_BIAS);
            end else begin
                r_cl <= {4'd0, half};
            end
        end
        if (i_cmd.out_load) begin
            r_o_value  <= r_value;
            r_o_status <= r_status;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_value  = r_o_value;
    assign o_out_status = r_o_status;
endmodule

// ===== sv/fat12_cluster_table_engine.sv =====
// fat12 cluster table engine: one result per item, one item in flight at a time.
// load writes one table word; read and write do a ram read then a merge; first free and
// count free scan one ram word per cycle; a zero search limit and a root or low sector
// go straight to the result; chain end reads one table entry per link it follows.
// after reset a clearing sweep writes zero to all 2048 table words, one per cycle;
// no item is taken during the sweep, configuration writes are taken at once.
module fat12_cluster_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fct_item_if.sink    i_item,
    fct_result_if.source o_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    fct_pkg::t_dp_cmd cmd;
    fct_pkg::t_dp_sts sts;
    fct_pkg::t_item   item;
    logic [15:0]      root;
    logic [fct_pkg::CNT_W-1:0] limit;
    logic             in_ready;

    assign item.func        = i_item.func;
    assign item.position    = i_item.position;
    assign item.entry_value = i_item.entry_value;
    assign item.pair_index  = i_item.pair_index;
    assign item.pair_data   = i_item.pair_data;
    assign item.dir_sector  = i_item.dir_sector;
    assign i_item.ready     = in_ready;

    fct_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_root    (root),
        .o_limit   (limit)
    );

    fct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_func  (i_item.func),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    fct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (item),
        .i_root       (root),
        .i_limit      (limit),
        .i_out_ready  (o_result.ready),
        .o_sts        (sts),
        .o_out_valid  (o_result.valid),
        .o_out_value  (o_result.value),
        .o_out_status (o_result.status)
    );

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result loaded over a pending result");

    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an item is in flight");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_result.valid)
        else $error("loaded result not presented");

    // table writes come from one source at a time
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.load_wr, cmd.rmw}))
        else $error("conflicting table writes");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> !i_item.ready)
        else $error("input taken during clearing sweep");
endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for fat12_cluster_table_engine: drives items, apb register
// writes and result backpressure, and predicts every result from its own table copy
// depends on fct_pkg, fct_item_if, fct_result_if and the engine rtl
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    localparam int WATCHDOG_CYCLES = 24_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 100;
    localparam int PHASE_COUNT     = 6;

    localparam logic [2:0] ADDR_ROOT  = {REG_ROOT, 2'b00};
    localparam logic [2:0] ADDR_LIMIT = {REG_LIMIT, 2'b00};

    // func codes the block leaves undefined
    localparam logic [2:0] F_SPARE_6 = 3'd6;
    localparam logic [2:0] F_SPARE_7 = 3'd7;

    typedef struct {
        logic [15:0] value;
        t_status     status;
    } fat_result_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    fct_item_if   item_bus ();
    fct_result_if result_bus ();

    fat12_cluster_table_engine dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_bus),
        .o_result  (result_bus),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // predicted table and register copies
    logic [WORD_W-1:0] fat_words [STORE_DEPTH];
    logic [15:0]       root_sector_q;
    logic [CNT_W-1:0]  search_limit_q;

    fat_result_t pending_results[$];
    int          fail_count;
    int          items_sent;
    int          burst_left;
    bit          gaps_on;
    bit          offering;
    int          hold_off_reqs;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [ENTRY_W-1:0] entry_at(input logic [ENTRY_W-1:0] pos);
        logic [WORD_W-1:0] w;
        w = fat_words[pos[11:1]];
        return pos[0] ? w[23:12] : w[11:0];
    endfunction

    function automatic fat_result_t predict_fat_result(input t_item it);
        fat_result_t       r;
        logic [WORD_W-1:0] w;
        logic [11:0]       nx;
        int                lim;
        int                cl;
        int                i;
        bit                done;
        r.value  = '0;
        r.status = ST_OK;
        case (it.func)
            F_LOAD: begin
                if (it.pair_index < WORDS) fat_words[it.pair_index] = it.pair_data;
            end
            F_READ: begin
                r.value = {4'b0, entry_at(it.position)};
            end
            F_WRITE: begin
                w = fat_words[it.position[11:1]];
                if (it.position[0]) w[23:12] = it.entry_value;
                else w[11:0] = it.entry_value;
                fat_words[it.position[11:1]] = w;
            end
            F_FREE: begin
                lim = (search_limit_q > ENTRIES) ? ENTRIES : int'(search_limit_q);
                r.status = ST_NO_FREE;
                for (i = 0; i < lim; i++) begin
                    if (entry_at(12'(i)) == 12'h000) begin
                        r.value  = 16'(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            F_CHAIN: begin
                if (it.dir_sector == root_sector_q) begin
                    r.value = it.dir_sector;
                end else if (it.dir_sector < SECTOR_BIAS) begin
                    r.status = ST_CHAIN_ERR;
                end else begin
                    cl   = int'(it.dir_sector) - SECTOR_BIAS;
                    done = 1'b0;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (cl >= ENTRIES) break;
                        nx = entry_at(12'(cl));
                        if (nx == END_MARK) begin
                            done = 1'b1;
                            break;
                        end
                        cl = int'(nx);
                    end
                    if (done) r.value = 16'(cl + SECTOR_BIAS);
                    else r.status = ST_CHAIN_ERR;
                end
            end
            F_COUNT: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (entry_at(12'(i)) == 12'h000) r.value++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    // stall pattern and compare against the oldest expectation
    initial begin : result_side
        fat_result_t want;
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int          hold_seen;
        result_bus.ready <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: value %0d status %0d",
                           result_bus.value, result_bus.status);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (result_bus.value !== want.value) begin
                        $error("value mismatch: expected %0d, got %0d",
                               want.value, result_bus.value);
                        fail_count++;
                    end
                    if (result_bus.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, result_bus.status);
                        fail_count++;
                    end
                end
            end
            if (hold_seen != hold_off_reqs) begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_TOGGLE));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   result_bus.ready <= 1'b1;
                    RX_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_bus.ready <= !result_bus.ready;
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    task automatic stop_offering();
        if (offering) begin
            item_bus.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                stop_offering();
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_bus.valid       <= 1'b1;
        item_bus.func        <= it.func;
        item_bus.position    <= it.position;
        item_bus.entry_value <= it.entry_value;
        item_bus.pair_index  <= it.pair_index;
        item_bus.pair_data   <= it.pair_data;
        item_bus.dir_sector  <= it.dir_sector;
        offering = 1'b1;
        do begin
            @(posedge i_clk);
        end while (item_bus.ready !== 1'b1);
        pending_results.push_back(predict_fat_result(it));
        items_sent++;
    endtask

    task automatic drain_results();
        stop_offering();
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_pready !== 1'b1);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    // only called with the block idle
    task automatic configure(input logic [15:0] root, input logic [CNT_W-1:0] limit);
        drain_results();
        write_reg(ADDR_ROOT, {16'b0, root});
        write_reg(ADDR_LIMIT, {19'b0, limit});
        root_sector_q  = root;
        search_limit_q = limit;
    endtask

    // unused fields carry random bits
    function automatic t_item make_item(input logic [2:0] func);
        t_item it;
        it.func        = func;
        it.position    = 12'($urandom);
        it.entry_value = 12'($urandom);
        it.pair_index  = 11'($urandom);
        it.pair_data   = 24'($urandom);
        it.dir_sector  = 16'($urandom);
        return it;
    endfunction

    task automatic do_op(input logic [2:0] func);
        send_item(make_item(func));
    endtask

    task automatic do_load(input logic [10:0] idx, input logic [23:0] data);
        t_item it;
        it = make_item(F_LOAD);
        it.pair_index = idx;
        it.pair_data  = data;
        send_item(it);
    endtask

    task automatic do_read(input logic [11:0] pos);
        t_item it;
        it = make_item(F_READ);
        it.position = pos;
        send_item(it);
    endtask

    task automatic do_write(input logic [11:0] pos, input logic [11:0] val);
        t_item it;
        it = make_item(F_WRITE);
        it.position    = pos;
        it.entry_value = val;
        send_item(it);
    endtask

    task automatic do_chain(input logic [15:0] sector);
        t_item it;
        it = make_item(F_CHAIN);
        it.dir_sector = sector;
        send_item(it);
    endtask

    function automatic logic [11:0] random_entry();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return END_MARK;
            default: return 12'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_table_access();
        do_load(11'd0, 24'hFFFFFF);
        do_read(12'd0);
        do_read(12'd1);
        do_load(11'd2047, 24'($urandom));
        do_read(12'd4095);
        do_write(12'd2, END_MARK);
        do_write(12'd3, 12'h000);
        do_read(12'd2);
        do_read(12'd3);
        do_write(12'd4095, 12'h5A5);
        do_read(12'd4095);
    endtask

    task automatic test_unused_codes();
        do_op(F_SPARE_6);
        do_op(F_SPARE_7);
    endtask

    // entries 0..2 are taken, entry 3 is the first free one
    task automatic test_first_free();
        configure(ROOT_RST, 13'd0);
        do_op(F_FREE);
        configure(ROOT_RST, 13'd3);
        do_op(F_FREE);
        configure(ROOT_RST, 13'd4);
        do_op(F_FREE);
        configure(ROOT_RST, 13'h1FFF);
        do_op(F_FREE);
    endtask

    task automatic test_chain_end();
        configure(16'hFFFF, LIMIT_RST);
        do_chain(16'hFFFF);
        do_chain(16'd0);
        do_chain(16'(SECTOR_BIAS - 1));
        do_chain(16'(ENTRIES + SECTOR_BIAS));
        do_chain(16'(SECTOR_BIAS));
        do_write(12'd10, 12'd4095);
        do_write(12'd4095, END_MARK);
        do_chain(16'(10 + SECTOR_BIAS));
        // entry pointing at itself never reaches the end mark
        do_write(12'd30, 12'd30);
        do_chain(16'(30 + SECTOR_BIAS));
    endtask

    task automatic test_count_free();
        do_op(F_COUNT);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_receiver_hold_off();
        int n;
        gaps_on = 1'b0;
        hold_off_reqs++;
        for (n = 0; n < 12; n++) begin
            if (n % 2 == 0) do_write(12'($urandom), random_entry());
            else do_read(12'($urandom));
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic walk_built_chain();
        logic [11:0] links[$];
        logic [11:0] c;
        bit          taken;
        int          k;
        int          j;
        k = $urandom_range(1, 6);
        while (links.size() < k) begin
            c     = 12'($urandom_range(0, ENTRIES - 2));
            taken = 1'b0;
            foreach (links[m]) if (links[m] == c) taken = 1'b1;
            if (!taken) links.push_back(c);
        end
        for (j = 0; j < k - 1; j++) do_write(links[j], links[j+1]);
        do_write(links[k-1], END_MARK);
        do_chain(16'(links[0]) + 16'(SECTOR_BIAS));
    endtask

    task automatic walk_odd_chain();
        case ($urandom_range(0, 4))
            0:       do_chain(root_sector_q);
            1:       do_chain(16'($urandom_range(0, SECTOR_BIAS - 1)));
            2:       do_chain(16'($urandom_range(ENTRIES + SECTOR_BIAS, 16'hFFFF)));
            3:       do_chain(16'($urandom_range(SECTOR_BIAS, ENTRIES + SECTOR_BIAS - 1)));
            default: do_chain(16'($urandom));
        endcase
    endtask

    task automatic random_access_burst();
        int n;
        int k;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 2))
                0:       do_read(12'($urandom));
                1:       do_write(12'($urandom), random_entry());
                default: do_load(11'($urandom), 24'($urandom));
            endcase
        end
    endtask

    // fill the low words so first-free scans go deeper
    task automatic fill_low_words();
        int n;
        int k;
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++) begin
            do_load(11'($urandom_range(0, 31)), 24'($urandom_range(1, 24'hFFFFFF)));
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0]      roots  [PHASE_COUNT];
        logic [CNT_W-1:0] limits [PHASE_COUNT];
        int               ph;
        int               start;
        int               pick;
        roots  = '{ROOT_RST, 16'd0, 16'hFFFF, 16'($urandom), 16'(SECTOR_BIAS),
                   16'($urandom_range(SECTOR_BIAS, ENTRIES + SECTOR_BIAS))};
        limits = '{LIMIT_RST, 13'd0, 13'(ENTRIES), 13'd1, 13'($urandom_range(0, ENTRIES)),
                   13'h1FFF};
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            configure(roots[ph], limits[ph]);
            gaps_on = (ph % 3 != 2);
            start   = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) random_access_burst();
                else if (pick < 70) walk_built_chain();
                else if (pick < 80) walk_odd_chain();
                else if (pick < 88) do_op(F_FREE);
                else if (pick < 91) do_op(F_COUNT);
                else if (pick < 94) do_op($urandom_range(0, 1) ? F_SPARE_6 : F_SPARE_7);
                else fill_low_words();
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n              <= 1'b0;
        i_psel               <= 1'b0;
        i_penable            <= 1'b0;
        i_pwrite             <= 1'b0;
        i_paddr              <= '0;
        i_pwdata             <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.func        <= F_LOAD;
        item_bus.position    <= '0;
        item_bus.entry_value <= '0;
        item_bus.pair_index  <= '0;
        item_bus.pair_data   <= '0;
        item_bus.dir_sector  <= '0;
        fail_count     = 0;
        items_sent     = 0;
        burst_left     = 0;
        gaps_on        = 1'b1;
        offering       = 1'b0;
        hold_off_reqs  = 0;
        foreach (fat_words[w]) fat_words[w] = '0;
        root_sector_q  = ROOT_RST;
        search_limit_q = LIMIT_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(ROOT_RST, LIMIT_RST);
        test_count_free();
        test_table_access();
        test_unused_codes();
        test_first_free();
        test_chain_end();
        configure(ROOT_RST, LIMIT_RST);
        test_count_free();
        test_receiver_hold_off();
        test_random_traffic();

        drain_results();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fct_pkg.sv
sv/fct_item_if.sv
sv/fct_result_if.sv
sv/fct_ram.sv
sv/fct_cfg.sv
sv/fct_ctrl.sv
sv/fct_dp.sv
sv/fat12_cluster_table_engine.sv
dv/testbench.sv
